/* rtl/tmfr_pkg.sv */
// shared types and constants for the timestamp matched frame ring
`default_nettype none
package tmfr_pkg;

   localparam int unsigned BUF_DEPTH_DEF   = 4;
   localparam int unsigned FRAME_DEPTH_DEF = 8;
   localparam logic [31:0] WINDOW_RESET    = 32'd1000000;
   localparam int unsigned STAMP_W         = 63;
   localparam int unsigned TAG_W           = 8;
   localparam int unsigned REQ_W           = 32;

   typedef enum logic [1:0] {
      CMD_BUFFER  = 2'd0,
      CMD_FRAME   = 2'd1,
      CMD_REPROC  = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LOCKED  = 2'd1,
      ST_NO_PUSH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIND,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word, apply arrival
      logic scan_clr;   // restart scan pointers
      logic scan_step;  // one slot x frame compare
      logic find_clr;   // start oldest-paired search
      logic find_step;  // one slot of the search
      logic finish;     // write result word
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic       need_scan;
      logic       scan_last;
      logic       find_last;
      logic       is_reproc;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/tmfr_ctrl.sv */
// sequencer for the timestamp matched frame ring
`default_nettype none
module tmfr_ctrl
   import tmfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output ctl_type      ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.is_reproc) begin
               ctl.find_clr = 1'b1;
               state_in     = S_FIND;
            end else if (!sts.need_scan) begin
               state_in = S_DONE;
            end else begin
               ctl.scan_step = 1'b1;
               if (sts.scan_last) state_in = S_DONE;
            end
         end
         S_FIND: begin
            ctl.find_step = 1'b1;
            if (sts.find_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.finish   = 1'b1;
               ctl.scan_clr = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* rtl/tmfr_dp.sv */
// slot and frame stores, match compare and result register
`default_nettype none
module tmfr_dp
   import tmfr_pkg::*;
#(
   parameter int unsigned BUF_DEPTH   = BUF_DEPTH_DEF,
   parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_type            ctl,
   output sts_type                 sts,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_data,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [STAMP_W-1:0] req_stamp,
   input  wire logic [TAG_W-1:0]   req_item_tag,
   input  wire logic [REQ_W-1:0]   req_request_id,
   output logic [1:0]              rsp_status,
   output logic                    rsp_give_back_valid,
   output logic [TAG_W-1:0]        rsp_give_back_tag,
   output logic                    rsp_push_valid,
   output logic [TAG_W-1:0]        rsp_push_buffer_tag,
   output logic [TAG_W-1:0]        rsp_push_frame_tag,
   output logic [REQ_W-1:0]        rsp_push_request_id
);

   localparam int unsigned BW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int unsigned FW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam logic [BW-1:0] BMAX = BW'(BUF_DEPTH - 1);
   localparam logic [FW-1:0] FMAX = FW'(FRAME_DEPTH - 1);

   logic [STAMP_W-1:0] slot_stamp_ff [BUF_DEPTH];
   logic [TAG_W-1:0]   slot_btag_ff  [BUF_DEPTH];
   logic [TAG_W-1:0]   slot_ftag_ff  [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] slot_hf_ff;
   logic [STAMP_W-1:0] fr_stamp_ff [FRAME_DEPTH];
   logic [TAG_W-1:0]   fr_tag_ff   [FRAME_DEPTH];
   logic [FRAME_DEPTH-1:0] fr_pres_ff;
   logic [BW-1:0] head_ff, tail_ff;
   logic [FW-1:0] fhead_ff;
   logic          locked_ff;
   logic [31:0]   window_ff;

   logic [1:0]         cmd_ff;
   logic [REQ_W-1:0]   reqid_ff;
   logic               busy_ff;   // arrival applied, scan needed
   logic [BW-1:0]      si_ff;
   logic [FW-1:0]      fj_ff;
   logic [BW-1:0]      fi_ff;
   logic               found_ff;
   logic [BW-1:0]      fidx_ff;
   logic               gb_v_ff;
   logic [TAG_W-1:0]   gb_tag_ff;
   logic [1:0]         st_ff;

   logic [1:0]         o_status_ff;
   logic               o_gbv_ff, o_pv_ff;
   logic [TAG_W-1:0]   o_gbt_ff, o_pbt_ff, o_pft_ff;
   logic [REQ_W-1:0]   o_rid_ff;

   logic [BW-1:0] head_nx, tail_nx;
   logic [FW-1:0] fhead_nx;
   logic          full;
   logic [STAMP_W-1:0] a, b, d;
   logic          hit, slot_open;
   logic          arrival, push_hit;
   logic [BUF_DEPTH-1:0] hf_clr;

   always_comb begin
      head_nx  = (head_ff == BMAX) ? '0 : head_ff + 1'b1;
      tail_nx  = (tail_ff == BMAX) ? '0 : tail_ff + 1'b1;
      fhead_nx = (fhead_ff == FMAX) ? '0 : fhead_ff + 1'b1;
      full     = (head_nx == tail_ff);
      a        = slot_stamp_ff[si_ff];
      b        = fr_stamp_ff[fj_ff];
      d        = (a >= b) ? a - b : b - a;
      slot_open = !slot_hf_ff[si_ff] && (a != '0);
      hit      = slot_open && fr_pres_ff[fj_ff] &&
                 ((d == '0) || (d < {31'd0, window_ff}));
      arrival  = (req_cmd == CMD_BUFFER) || (req_cmd == CMD_FRAME);
      push_hit = (cmd_ff == CMD_REPROC) && found_ff;
      // paired flags cleared for the new head and, when full, the evicted tail
      hf_clr   = (BUF_DEPTH'(1) << head_ff) |
                 (full ? (BUF_DEPTH'(1) << tail_ff) : '0);
   end

   assign sts.need_scan = busy_ff;
   assign sts.scan_last = (si_ff == BMAX) &&
                          (hit || !slot_open || fj_ff == FMAX);
   assign sts.find_last = found_ff || (fi_ff == head_ff) ||
                          (slot_hf_ff[fi_ff]) ||
                          ((fi_ff == BMAX ? '0 : fi_ff + 1'b1) == head_ff);
   assign sts.is_reproc = (cmd_ff == CMD_REPROC);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_hf_ff    <= '0;
         fr_pres_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fhead_ff      <= '0;
         locked_ff     <= 1'b0;
         window_ff     <= WINDOW_RESET;
         busy_ff       <= 1'b0;
         si_ff         <= '0;
         fj_ff         <= '0;
         for (int k = 0; k < BUF_DEPTH; k++) begin
            slot_stamp_ff[k] <= '0;
            slot_btag_ff[k]  <= '0;
            slot_ftag_ff[k]  <= '0;
         end
      end else begin
         if (csr_we) window_ff <= csr_data;
         if (ctl.load) begin
            cmd_ff    <= req_cmd;
            reqid_ff  <= req_request_id;
            st_ff     <= (locked_ff && arrival) ? ST_LOCKED : ST_OK;
            gb_v_ff   <= (req_cmd == CMD_BUFFER) && (locked_ff || full);
            gb_tag_ff <= (req_cmd != CMD_BUFFER) ? '0 :
                         locked_ff ? req_item_tag :
                         full ? slot_btag_ff[tail_ff] : '0;
            busy_ff   <= !locked_ff && arrival;
            case (cmd_type'(req_cmd))
               CMD_BUFFER: begin
                  if (!locked_ff) begin
                     if (full) begin
                        slot_stamp_ff[tail_ff] <= '0;
                        slot_btag_ff[tail_ff]  <= '0;
                        slot_ftag_ff[tail_ff]  <= '0;
                        tail_ff <= tail_nx;
                     end
                     slot_stamp_ff[head_ff] <= req_stamp;
                     slot_btag_ff[head_ff]  <= req_item_tag;
                     slot_ftag_ff[head_ff]  <= '0;
                     slot_hf_ff <= slot_hf_ff & ~hf_clr;
                     head_ff <= head_nx;
                  end
               end
               CMD_FRAME: begin
                  if (!locked_ff) begin
                     fr_stamp_ff[fhead_ff] <= req_stamp;
                     fr_tag_ff[fhead_ff]   <= req_item_tag;
                     fr_pres_ff[fhead_ff]  <= 1'b1;
                     fhead_ff <= fhead_nx;
                  end
               end
               CMD_REPROC: ;
               CMD_RELEASE: locked_ff <= 1'b0;
               default: ;
            endcase
         end
         if (ctl.scan_clr) begin
            si_ff <= '0;
            fj_ff <= '0;
         end
         if (ctl.scan_step) begin
            if (hit) begin
               slot_hf_ff[si_ff]   <= 1'b1;
               slot_ftag_ff[si_ff] <= fr_tag_ff[fj_ff];
               fr_pres_ff[fj_ff]   <= 1'b0;
            end
            if (hit || !slot_open || fj_ff == FMAX) begin
               fj_ff <= '0;
               si_ff <= (si_ff == BMAX) ? '0 : si_ff + 1'b1;
               if (si_ff == BMAX) busy_ff <= 1'b0;
            end else begin
               fj_ff <= fj_ff + 1'b1;
            end
         end
         if (ctl.find_clr) begin
            found_ff <= 1'b0;
            fi_ff    <= tail_ff;
         end
         if (ctl.find_step) begin
            if (fi_ff != head_ff && slot_hf_ff[fi_ff]) begin
               found_ff <= 1'b1;
               fidx_ff  <= fi_ff;
            end else if (fi_ff != head_ff) begin
               fi_ff <= (fi_ff == BMAX) ? '0 : fi_ff + 1'b1;
            end
         end
         if (ctl.finish) begin
            o_status_ff <= ((cmd_ff == CMD_REPROC) && !found_ff) ? ST_NO_PUSH : st_ff;
            o_gbv_ff    <= gb_v_ff;
            o_gbt_ff    <= gb_tag_ff;
            o_pv_ff     <= push_hit;
            o_pbt_ff    <= push_hit ? slot_btag_ff[fidx_ff] : '0;
            o_pft_ff    <= push_hit ? slot_ftag_ff[fidx_ff] : '0;
            o_rid_ff    <= push_hit ? reqid_ff : '0;
            if (push_hit) locked_ff <= 1'b1;
         end
      end
   end

   assign rsp_status          = o_status_ff;
   assign rsp_give_back_valid = o_gbv_ff;
   assign rsp_give_back_tag   = o_gbt_ff;
   assign rsp_push_valid      = o_pv_ff;
   assign rsp_push_buffer_tag = o_pbt_ff;
   assign rsp_push_frame_tag  = o_pft_ff;
   assign rsp_push_request_id = o_rid_ff;

endmodule
`default_nettype wire

/* rtl/timestamp_matched_frame_ring.sv */
// top level of the timestamp matched frame ring
// Pairs captured buffers with metadata frames by timestamp. One request word
// is taken at a time. After the accept cycle, an arrival that is not locked
// out runs a match scan over the buffer slots, one slot x frame compare per
// cycle: a slot that is already paired or has stamp zero is passed over
// after a single compare, any other is compared against up to FRAME_DEPTH
// frames. Every other word is dispatched without a scan; a reprocess request
// walks the buffer ring from the tail one slot per cycle. The response
// register is then loaded, waiting while the previous response word is
// still stalled. The match scan uses a single shared 63-bit subtract and
// window compare. One response word is produced for every request word.
// match_window is to be written on the csr port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module timestamp_matched_frame_ring
   import tmfr_pkg::*;
#(
   parameter int unsigned BUF_DEPTH   = BUF_DEPTH_DEF,
   parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_data,
   // request words
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [STAMP_W-1:0] req_stamp,
   input  wire logic [TAG_W-1:0]   req_item_tag,
   input  wire logic [REQ_W-1:0]   req_request_id,
   // response words
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_give_back_valid,
   output logic [TAG_W-1:0]        rsp_give_back_tag,
   output logic                    rsp_push_valid,
   output logic [TAG_W-1:0]        rsp_push_buffer_tag,
   output logic [TAG_W-1:0]        rsp_push_frame_tag,
   output logic [REQ_W-1:0]        rsp_push_request_id
);

   ctl_type ctl;
   sts_type sts;

   // register always writable
   assign csr_ready = 1'b1;

   tmfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   tmfr_dp #(
      .BUF_DEPTH   (BUF_DEPTH),
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .csr_we              (csr_valid),
      .csr_data            (csr_data),
      .req_cmd             (req_cmd),
      .req_stamp           (req_stamp),
      .req_item_tag        (req_item_tag),
      .req_request_id      (req_request_id),
      .rsp_status          (rsp_status),
      .rsp_give_back_valid (rsp_give_back_valid),
      .rsp_give_back_tag   (rsp_give_back_tag),
      .rsp_push_valid      (rsp_push_valid),
      .rsp_push_buffer_tag (rsp_push_buffer_tag),
      .rsp_push_frame_tag  (rsp_push_frame_tag),
      .rsp_push_request_id (rsp_push_request_id)
   );

endmodule
`default_nettype wire

/* rtl/tmfr_checker.sv */
// port-level checks for the timestamp matched frame ring
`default_nettype none
module tmfr_checker
   import tmfr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_give_back_valid,
   input wire logic       rsp_push_valid
);

   // accepted request word cannot be answered in the next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("response too early");

   // a push is always ok status
   a_push_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_push_valid) |-> (rsp_status == ST_OK))
      else $error("push with bad status");

   // nothing-to-push has no side effects
   a_nopush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NO_PUSH) |->
      (!rsp_push_valid && !rsp_give_back_valid))
      else $error("no-push word carries data");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind timestamp_matched_frame_ring tmfr_checker u_tmfr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_give_back_valid (rsp_give_back_valid),
   .rsp_push_valid      (rsp_push_valid)
);
`default_nettype wire
